// ===== sv/rwc_pkg.sv =====
// shared types and constants for the rgb window convolution unit
// no dependencies
package rwc_pkg;

  localparam int MAX_KERNEL     = 5;
  localparam int KERNEL_TAPS    = MAX_KERNEL * MAX_KERNEL;
  localparam int OFF_MAX        = (MAX_KERNEL - 1) / 2;
  localparam int COL_BANKS      = MAX_KERNEL;
  localparam int ROW_BANKS      = 3 * OFF_MAX + 1;
  localparam int HEIGHT_LIMIT   = 1024;
  localparam int ROW_W          = 10;
  localparam int COEF_FRAC_BITS = 12;
  localparam int RB_W           = 3;
  localparam int CB_W           = 3;

  typedef enum logic [1:0] {
    REQ_PIXEL = 2'd0,
    REQ_LOAD  = 2'd1,
    REQ_DRAIN = 2'd2,
    REQ_NONE  = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    CFG_WIDTH  = 2'd0,
    CFG_HEIGHT = 2'd1,
    CFG_FSIZE  = 2'd2,
    CFG_GRAY   = 2'd3
  } cfg_idx_t;

  // red in the lowest byte
  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } rgb_t;

  typedef struct packed {
    logic                                  emit;
    logic                                  last;
    logic                                  load;
    logic [4:0]                            lidx;
    logic signed [15:0]                    lval;
    logic [MAX_KERNEL-1:0][RB_W-1:0]       rb;
    logic [MAX_KERNEL-1:0][CB_W-1:0]       cb;
  } ctl_t;

  typedef struct packed {
    logic last;
    rgb_t pix;
  } out_t;

endpackage

// ===== sv/rwc_line_mem.sv =====
// banked pixel store: row banks by row, column banks by column
// uses rwc_pkg
module rwc_line_mem import rwc_pkg::*; #(
  parameter int DEPTH  = 205,
  parameter int ADDR_W = 8
) (
  input  logic                                clk,
  input  logic                                wr_en,
  input  logic [RB_W-1:0]                     wr_rb,
  input  logic [CB_W-1:0]                     wr_cb,
  input  logic [ADDR_W-1:0]                   wr_addr,
  input  rgb_t                                wr_data,
  input  logic [COL_BANKS-1:0][ADDR_W-1:0]    rd_addr,
  output rgb_t                                rd_data [ROW_BANKS][COL_BANKS]
);

  for (genvar b = 0; b < ROW_BANKS; b++) begin : g_row
    for (genvar c = 0; c < COL_BANKS; c++) begin : g_col
      rgb_t mem [DEPTH];
      always_ff @(posedge clk) begin
        if (wr_en && wr_rb == RB_W'(b) && wr_cb == CB_W'(c)) begin
          mem[wr_addr] <= wr_data;
        end
        rd_data[b][c] <= mem[rd_addr[c]];
      end
    end
  end

endmodule

// ===== sv/rgb_window_convolution_unit.sv =====
// throughput: one item per cycle while in_tready is high; the pixel store has one read per bank per cycle
// in_tready drops only when sixteen results are outstanding
// reset: config to 1024x1024, size 3, color; counters clear; stores are not cleared
// uses rwc_pkg and rwc_line_mem
module rgb_window_convolution_unit import rwc_pkg::*; #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // red, green, blue, coef_index, coef_value
  input  logic [1:0]  in_tuser,   // req_type
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // out_red, out_green, out_blue
  output logic        out_tlast,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [10:0] cfg_data
);

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int WW  = CW + 1;
  localparam int QD  = (MAX_WIDTH + COL_BANKS - 1) / COL_BANKS;
  localparam int QW  = $clog2(QD);
  localparam int NW  = CW + ROW_W + 1;
  localparam int FD  = 16;
  localparam int FPW = 4;

  logic [10:0] width_r, height_r;
  logic [2:0]  fsize_r;
  logic        gray_r;

  logic [WW-1:0]    w_eff;
  logic [ROW_W:0]   h_eff;
  logic [1:0]       off;
  logic [CW-1:0]    wm1, wq_full;
  logic [ROW_W-1:0] hm1, hq;
  logic [CW+13:0]   wprod;
  logic [ROW_W+13:0] hprod;
  logic [QW-1:0]    wq;
  logic [CB_W-1:0]  wr;
  logic [RB_W-1:0]  hb;
  logic [NW-1:0]    lag;

  always_comb begin
    if (width_r == 11'd0) w_eff = WW'(1);
    else if (32'(width_r) > 32'(MAX_WIDTH)) w_eff = WW'(MAX_WIDTH);
    else w_eff = WW'(width_r);
    if (height_r == 11'd0) h_eff = (ROW_W+1)'(1);
    else if (32'(height_r) > 32'(HEIGHT_LIMIT)) h_eff = (ROW_W+1)'(HEIGHT_LIMIT);
    else h_eff = (ROW_W+1)'(height_r);
    if (fsize_r >= 3'd5) off = 2'd2;
    else if (fsize_r >= 3'd3) off = 2'd1;
    else off = 2'd0;
    wm1     = CW'(w_eff - WW'(1));
    hm1     = ROW_W'(h_eff - (ROW_W+1)'(1));
    wprod   = (CW+14)'(wm1) * (CW+14)'(13108);
    wq_full = CW'(wprod >> 16);
    wq      = QW'(wq_full);
    wr      = CB_W'(wm1 - wq_full * CW'(5));
    hprod   = (ROW_W+14)'(hm1) * (ROW_W+14)'(9363);
    hq      = ROW_W'(hprod >> 16);
    hb      = RB_W'(hm1 - hq * ROW_W'(7));
    unique case (off)
      2'd2:    lag = (NW'(w_eff) << 1) + NW'(2);
      2'd1:    lag = NW'(w_eff) + NW'(1);
      default: lag = '0;
    endcase
  end

  // position counters
  logic [CW-1:0]    in_col_r, out_col_r;
  logic [QW-1:0]    in_cq_r, out_cq_r;
  logic [CB_W-1:0]  in_cr_r, out_cr_r;
  logic [ROW_W-1:0] in_row_r, out_row_r;
  logic [RB_W-1:0]  in_rb_r, out_rb_r;
  logic [NW-1:0]    in_n_r;
  logic             rcvd_r;

  logic [FPW:0] resv_r;
  logic         acc, is_pix, emit, is_load, in_last, out_last, pop;
  req_t         req;

  assign in_tready = resv_r < (FPW+1)'(FD);
  assign acc       = in_tvalid && in_tready;
  assign req       = req_t'(in_tuser);
  assign is_pix    = acc && req == REQ_PIXEL && !rcvd_r;
  assign emit      = (is_pix && in_n_r >= lag) || (acc && req == REQ_DRAIN && rcvd_r);
  assign is_load   = acc && req == REQ_LOAD && in_tdata[28:24] < 5'(KERNEL_TAPS);
  assign in_last   = in_row_r == hm1 && in_col_r == wm1;
  assign out_last  = out_row_r == hm1 && out_col_r == wm1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r   <= 11'd1024;
      height_r  <= 11'd1024;
      fsize_r   <= 3'd3;
      gray_r    <= 1'b0;
      in_col_r  <= '0; in_cq_r  <= '0; in_cr_r  <= '0; in_row_r  <= '0; in_rb_r  <= '0;
      out_col_r <= '0; out_cq_r <= '0; out_cr_r <= '0; out_row_r <= '0; out_rb_r <= '0;
      in_n_r    <= '0;
      rcvd_r    <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_WIDTH:  width_r  <= cfg_data;
        CFG_HEIGHT: height_r <= cfg_data;
        CFG_FSIZE:  fsize_r  <= cfg_data[2:0];
        CFG_GRAY:   gray_r   <= cfg_data[0];
      endcase
      if (cfg_idx_t'(cfg_index) != CFG_GRAY) begin
        in_col_r  <= '0; in_cq_r  <= '0; in_cr_r  <= '0; in_row_r  <= '0; in_rb_r  <= '0;
        out_col_r <= '0; out_cq_r <= '0; out_cr_r <= '0; out_row_r <= '0; out_rb_r <= '0;
        in_n_r    <= '0;
        rcvd_r    <= 1'b0;
      end
    end else if (emit && out_last) begin
      // frame wrap
      in_col_r  <= '0; in_cq_r  <= '0; in_cr_r  <= '0; in_row_r  <= '0; in_rb_r  <= '0;
      out_col_r <= '0; out_cq_r <= '0; out_cr_r <= '0; out_row_r <= '0; out_rb_r <= '0;
      in_n_r    <= '0;
      rcvd_r    <= 1'b0;
    end else begin
      if (is_pix) begin
        in_n_r <= in_n_r + NW'(1);
        if (in_last) begin
          rcvd_r <= 1'b1;
        end else if (in_col_r == wm1) begin
          in_col_r <= '0;
          in_cq_r  <= '0;
          in_cr_r  <= '0;
          in_row_r <= in_row_r + ROW_W'(1);
          in_rb_r  <= (in_rb_r == RB_W'(ROW_BANKS - 1)) ? '0 : in_rb_r + RB_W'(1);
        end else begin
          in_col_r <= in_col_r + CW'(1);
          if (in_cr_r == CB_W'(COL_BANKS - 1)) begin
            in_cr_r <= '0;
            in_cq_r <= in_cq_r + QW'(1);
          end else begin
            in_cr_r <= in_cr_r + CB_W'(1);
          end
        end
      end
      if (emit) begin
        if (out_col_r == wm1) begin
          out_col_r <= '0;
          out_cq_r  <= '0;
          out_cr_r  <= '0;
          out_row_r <= out_row_r + ROW_W'(1);
          out_rb_r  <= (out_rb_r == RB_W'(ROW_BANKS - 1)) ? '0 : out_rb_r + RB_W'(1);
        end else begin
          out_col_r <= out_col_r + CW'(1);
          if (out_cr_r == CB_W'(COL_BANKS - 1)) begin
            out_cr_r <= '0;
            out_cq_r <= out_cq_r + QW'(1);
          end else begin
            out_cr_r <= out_cr_r + CB_W'(1);
          end
        end
      end
    end
  end

  // window addresses, clamped to the image edge
  logic [MAX_KERNEL-1:0][QW-1:0]   cq;
  logic [MAX_KERNEL-1:0][CB_W-1:0] cr;
  logic [MAX_KERNEL-1:0][RB_W-1:0] rbk;
  logic [COL_BANKS-1:0][QW-1:0]    caddr;

  always_comb begin
    logic [CW+1:0]    cs;
    logic [ROW_W+1:0] rs;
    logic [3:0]       rr;
    for (int i = 0; i < MAX_KERNEL; i++) begin
      cs = (CW+2)'(out_col_r) + (CW+2)'(i);
      rr = 4'(out_cr_r) + 4'(i);
      if (cs < (CW+2)'(OFF_MAX)) begin
        cq[i] = '0;
        cr[i] = '0;
      end else if (cs >= (CW+2)'(w_eff) + (CW+2)'(OFF_MAX)) begin
        cq[i] = wq;
        cr[i] = wr;
      end else if (rr < 4'(OFF_MAX)) begin
        cq[i] = out_cq_r - QW'(1);
        cr[i] = CB_W'(rr + 4'(COL_BANKS - OFF_MAX));
      end else if (rr >= 4'(COL_BANKS + OFF_MAX)) begin
        cq[i] = out_cq_r + QW'(1);
        cr[i] = CB_W'(rr - 4'(COL_BANKS + OFF_MAX));
      end else begin
        cq[i] = out_cq_r;
        cr[i] = CB_W'(rr - 4'(OFF_MAX));
      end
      rs = (ROW_W+2)'(out_row_r) + (ROW_W+2)'(i);
      rr = 4'(out_rb_r) + 4'(i);
      if (rs < (ROW_W+2)'(OFF_MAX)) begin
        rbk[i] = '0;
      end else if (rs >= (ROW_W+2)'(h_eff) + (ROW_W+2)'(OFF_MAX)) begin
        rbk[i] = hb;
      end else if (rr < 4'(OFF_MAX)) begin
        rbk[i] = RB_W'(rr + 4'(ROW_BANKS - OFF_MAX));
      end else if (rr >= 4'(ROW_BANKS + OFF_MAX)) begin
        rbk[i] = RB_W'(rr - 4'(ROW_BANKS + OFF_MAX));
      end else begin
        rbk[i] = RB_W'(rr - 4'(OFF_MAX));
      end
    end
    for (int j = 0; j < COL_BANKS; j++) begin
      caddr[j] = '0;
      for (int i = 0; i < MAX_KERNEL; i++) begin
        if (cr[i] == CB_W'(j)) caddr[j] = cq[i];
      end
    end
  end

  // stage 1: write to pixel store
  ctl_t                          ctl1_r, ctl2_r, ctl3_r;
  logic [COL_BANKS-1:0][QW-1:0]  caddr1_r, caddr2_r;
  logic                          wr1_r;
  logic [RB_W-1:0]               wrb1_r;
  logic [CB_W-1:0]               wcb1_r;
  logic [QW-1:0]                 wq1_r;
  rgb_t                          wd1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl1_r <= '0;
      ctl2_r <= '0;
      ctl3_r <= '0;
      wr1_r  <= 1'b0;
    end else begin
      ctl1_r.emit <= emit;
      ctl1_r.last <= out_last;
      ctl1_r.load <= is_load;
      ctl1_r.lidx <= in_tdata[28:24];
      ctl1_r.lval <= in_tdata[44:29];
      ctl1_r.rb   <= rbk;
      ctl1_r.cb   <= cr;
      wr1_r       <= is_pix;
      ctl2_r      <= ctl1_r;
      ctl3_r      <= ctl2_r;
    end
  end

  always_ff @(posedge clk) begin
    caddr1_r <= caddr;
    caddr2_r <= caddr1_r;
    wrb1_r   <= in_rb_r;
    wcb1_r   <= in_cr_r;
    wq1_r    <= in_cq_r;
    wd1_r    <= in_tdata[23:0];
  end

  rgb_t rd_q [ROW_BANKS][COL_BANKS];

  rwc_line_mem #(
    .DEPTH  (QD),
    .ADDR_W (QW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr1_r),
    .wr_rb   (wrb1_r),
    .wr_cb   (wcb1_r),
    .wr_addr (wq1_r),
    .wr_data (wd1_r),
    .rd_addr (caddr2_r),
    .rd_data (rd_q)
  );

  // stage 3: window select and coefficients
  logic signed [15:0] coef_r [KERNEL_TAPS];
  rgb_t               pix4_r [KERNEL_TAPS];
  logic signed [15:0] cf4_r  [KERNEL_TAPS];
  rgb_t               pix_s  [KERNEL_TAPS];
  logic signed [15:0] cf_s   [KERNEL_TAPS];

  for (genvar p = 0; p < KERNEL_TAPS; p++) begin : g_tap
    localparam int Y   = p / MAX_KERNEL;
    localparam int X   = p % MAX_KERNEL;
    localparam int DY  = Y - OFF_MAX;
    localparam int DX  = X - OFF_MAX;
    localparam int AY  = DY < 0 ? -DY : DY;
    localparam int AX  = DX < 0 ? -DX : DX;
    localparam int AM  = AY > AX ? AY : AX;
    localparam int K1  = (DY + 1) * 3 + (DX + 1);
    localparam int K2  = Y * MAX_KERNEL + X;
    localparam int K1C = (AM <= 1) ? K1 : 0;
    always_comb begin
      if (32'(off) < AM) begin
        pix_s[p] = '0;
        cf_s[p]  = '0;
      end else begin
        pix_s[p] = rd_q[ctl3_r.rb[Y]][ctl3_r.cb[X]];
        unique case (off)
          2'd2:    cf_s[p] = coef_r[K2];
          2'd1:    cf_s[p] = coef_r[K1C];
          default: cf_s[p] = coef_r[0];
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl3_r.load) begin
      coef_r[ctl3_r.lidx] <= ctl3_r.lval;
    end
    for (int p = 0; p < KERNEL_TAPS; p++) begin
      pix4_r[p] <= pix_s[p];
      cf4_r[p]  <= cf_s[p];
    end
  end

  // stages 4 to 6: products, row sums, total
  logic signed [24:0] prod5_r [KERNEL_TAPS][3];
  logic signed [27:0] rsum6_r [MAX_KERNEL][3];
  logic               emit4_r, emit5_r, emit6_r, last4_r, last5_r, last6_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      emit4_r <= 1'b0;
      emit5_r <= 1'b0;
      emit6_r <= 1'b0;
    end else begin
      emit4_r <= ctl3_r.emit;
      emit5_r <= emit4_r;
      emit6_r <= emit5_r;
    end
  end

  always_ff @(posedge clk) begin
    logic signed [27:0] acc_s;
    last4_r <= ctl3_r.last;
    last5_r <= last4_r;
    last6_r <= last5_r;
    for (int p = 0; p < KERNEL_TAPS; p++) begin
      prod5_r[p][0] <= $signed({1'b0, pix4_r[p].red})   * cf4_r[p];
      prod5_r[p][1] <= $signed({1'b0, pix4_r[p].green}) * cf4_r[p];
      prod5_r[p][2] <= $signed({1'b0, pix4_r[p].blue})  * cf4_r[p];
    end
    for (int y = 0; y < MAX_KERNEL; y++) begin
      for (int ch = 0; ch < 3; ch++) begin
        acc_s = '0;
        for (int x = 0; x < MAX_KERNEL; x++) begin
          acc_s = acc_s + 28'(prod5_r[y*MAX_KERNEL+x][ch]);
        end
        rsum6_r[y][ch] <= acc_s;
      end
    end
  end

  function automatic logic [7:0] finish_sum(input logic signed [30:0] s);
    logic signed [30:0] v;
    v = s >>> COEF_FRAC_BITS;
    if (s <= 0) return 8'd0;
    if (v > 31'sd255) return 8'd255;
    return v[7:0];
  endfunction

  out_t res;

  always_comb begin
    logic signed [30:0] tot [3];
    for (int ch = 0; ch < 3; ch++) begin
      tot[ch] = '0;
      for (int y = 0; y < MAX_KERNEL; y++) begin
        tot[ch] = tot[ch] + 31'(rsum6_r[y][ch]);
      end
    end
    res.last      = last6_r;
    res.pix.red   = finish_sum(tot[0]);
    res.pix.green = gray_r ? res.pix.red : finish_sum(tot[1]);
    res.pix.blue  = gray_r ? res.pix.red : finish_sum(tot[2]);
  end

  // output queue
  out_t         fifo_r [FD];
  logic [FPW-1:0] wp_r, rp_r;
  logic [FPW:0]   cnt_r;

  assign pop        = out_tvalid && out_tready;
  assign out_tvalid = cnt_r != '0;
  assign out_tdata  = fifo_r[rp_r].pix;
  assign out_tlast  = fifo_r[rp_r].last;

  always_ff @(posedge clk) begin
    if (emit6_r) fifo_r[wp_r] <= res;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r   <= '0;
      rp_r   <= '0;
      cnt_r  <= '0;
      resv_r <= '0;
    end else begin
      if (emit6_r) wp_r <= wp_r + FPW'(1);
      if (pop) rp_r <= rp_r + FPW'(1);
      cnt_r  <= cnt_r + (FPW+1)'(emit6_r) - (FPW+1)'(pop);
      resv_r <= resv_r + (FPW+1)'(emit) - (FPW+1)'(pop);
    end
  end

endmodule

// ===== sim/tb_rgb_window_convolution_unit.sv =====
// self-checking testbench for rgb_window_convolution_unit: random frames, coefficient
// loads, drains and noise items, checked against a scoreboard that predicts every result
// depends on rwc_pkg and the unit's rtl
module tb_rgb_window_convolution_unit;
  import rwc_pkg::*;

  localparam int STORE_DEPTH = MAX_KERNEL * (1024 + 1);
  localparam int WD_LIMIT    = 4000;

  typedef struct {
    rgb_t pix;
    logic last;
  } pixel_result_t;

  class conv_scoreboard;
    rgb_t                line_mem[STORE_DEPTH];
    logic signed [15:0]  coef[KERNEL_TAPS];
    int unsigned         in_col, in_row, out_col, out_row;
    bit                  got_frame;
    int unsigned         width_r, height_r, fsize_r;
    bit                  gray_r;
    pixel_result_t       pending[$];
    int                  errors, checked;

    function new();
      foreach (line_mem[i]) line_mem[i] = '0;
      foreach (coef[i]) coef[i] = '0;
      width_r = 1024; height_r = 1024; fsize_r = 3; gray_r = 0;
      errors = 0; checked = 0;
      restart();
    endfunction

    function void restart();
      in_col = 0; in_row = 0; out_col = 0; out_row = 0; got_frame = 0;
    endfunction

    function int unsigned eff_w();
      if (width_r == 0) return 1;
      return (width_r > 1024) ? 1024 : width_r;
    endfunction

    function int unsigned eff_h();
      if (height_r == 0) return 1;
      return (height_r > HEIGHT_LIMIT) ? HEIGHT_LIMIT : height_r;
    endfunction

    function int unsigned eff_off();
      int unsigned off;
      off = (fsize_r == 0) ? 0 : (fsize_r - 1) / 2;
      return (off > OFF_MAX) ? OFF_MAX : off;
    endfunction

    function void write_reg(cfg_idx_t idx, logic [10:0] v);
      case (idx)
        CFG_WIDTH: begin
          width_r = v; restart();
        end
        CFG_HEIGHT: begin
          height_r = v; restart();
        end
        CFG_FSIZE: begin
          fsize_r = v[2:0]; restart();
        end
        CFG_GRAY: begin
          gray_r = v[0];
        end
      endcase
    endfunction

    function logic [7:0] clamp_sum(longint s);
      longint v;
      if (s <= 0) return 8'd0;
      v = s >>> COEF_FRAC_BITS;
      return (v > 255) ? 8'd255 : v[7:0];
    endfunction

    function void emit_next();
      int unsigned w, h, off, k, idx;
      int cy, cx;
      longint sr, sg, sb;
      longint c;
      rgb_t px;
      pixel_result_t r;
      w = eff_w(); h = eff_h(); off = eff_off();
      sr = 0; sg = 0; sb = 0; k = 0;
      for (int dy = -int'(off); dy <= int'(off); dy++) begin
        cy = int'(out_row) + dy;
        if (cy < 0) cy = 0;
        if (cy > int'(h) - 1) cy = int'(h) - 1;
        for (int dx = -int'(off); dx <= int'(off); dx++) begin
          cx = int'(out_col) + dx;
          if (cx < 0) cx = 0;
          if (cx > int'(w) - 1) cx = int'(w) - 1;
          idx = (cy * w + cx) % STORE_DEPTH;
          px = line_mem[idx];
          c = coef[k];
          sr += longint'(px.red) * c;
          sg += longint'(px.green) * c;
          sb += longint'(px.blue) * c;
          k++;
        end
      end
      r.pix.red = clamp_sum(sr);
      r.pix.green = gray_r ? r.pix.red : clamp_sum(sg);
      r.pix.blue = gray_r ? r.pix.red : clamp_sum(sb);
      r.last = (out_row == h - 1) && (out_col == w - 1);
      pending.push_back(r);
      if (r.last) restart();
      else if (out_col + 1 >= w) begin
        out_col = 0; out_row++;
      end else out_col++;
    endfunction

    function void note_input(req_t req, logic [47:0] d);
      int unsigned w, h, n, lag;
      case (req)
        REQ_LOAD: begin
          if (d[28:24] < KERNEL_TAPS) coef[d[28:24]] = d[44:29];
        end
        REQ_PIXEL: begin
          if (!got_frame) begin
            w = eff_w(); h = eff_h();
            n = in_row * w + in_col;
            line_mem[n % STORE_DEPTH] = d[23:0];
            if (in_row == h - 1 && in_col == w - 1) got_frame = 1;
            else if (in_col + 1 >= w) begin
              in_col = 0; in_row++;
            end else in_col++;
            lag = eff_off() * w + eff_off();
            if (n >= lag) emit_next();
          end
        end
        REQ_DRAIN: begin
          if (got_frame) emit_next();
        end
        default: ;
      endcase
    endfunction

    task report(string msg);
      $display("error: %s", msg);
      errors++;
    endtask

    task check(logic [23:0] d, logic last);
      pixel_result_t r;
      rgb_t got;
      got = d;
      if (pending.size() == 0) begin
        report($sformatf("result %0d arrived with nothing expected", checked));
      end else begin
        r = pending.pop_front();
        if (got.red !== r.pix.red)
          report($sformatf("result %0d red %0d, want %0d", checked, got.red, r.pix.red));
        if (got.green !== r.pix.green)
          report($sformatf("result %0d green %0d, want %0d", checked, got.green,
                           r.pix.green));
        if (got.blue !== r.pix.blue)
          report($sformatf("result %0d blue %0d, want %0d", checked, got.blue,
                           r.pix.blue));
        if (last !== r.last)
          report($sformatf("result %0d tlast %0b, want %0b", checked, last, r.last));
      end
      checked++;
    endtask
  endclass

  logic        clk, rst_n;
  logic        in_tvalid, in_tready;
  logic [47:0] in_tdata;   // red, green, blue, coef_index, coef_value
  logic [1:0]  in_tuser;   // req_type
  logic        out_tvalid, out_tready;
  logic [23:0] out_tdata;  // out_red, out_green, out_blue
  logic        out_tlast;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [10:0] cfg_data;

  conv_scoreboard sb;
  int  items_sent, settings_run, idle_cycles;
  bit  calm_in, calm_out;

  rgb_window_convolution_unit u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // transfer monitor and watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) sb.note_input(req_t'(in_tuser), in_tdata);
      if (out_tvalid && out_tready) sb.check(out_tdata, out_tlast);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WD_LIMIT) begin
        $display("timeout: no transfer for %0d cycles", WD_LIMIT);
        $display("rgb_window_convolution_unit: mismatch");
        $finish;
      end
    end
  end

  function int draw_gap(bit calm);
    if (calm) return 0;
    return $urandom_range(0, 19);
  endfunction

  // receiver with random stalls
  initial begin
    int stall;
    out_tready = 1'b0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      stall = draw_gap(calm_out);
      if (stall > 0) begin
        out_tready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready = 1'b1;
      do @(posedge clk); while (!out_tvalid);
      @(negedge clk);
    end
  end

  task send_item(req_t req, rgb_t pix, logic [4:0] ci, logic [15:0] cv);
    int gap;
    gap = draw_gap(calm_in);
    if (gap > 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tuser = req;
    in_tdata = {3'b000, cv, ci, pix};
    in_tvalid = 1'b1;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
    items_sent++;
  endtask

  task send_pixel();
    send_item(REQ_PIXEL, rgb_t'($urandom), 5'($urandom), 16'($urandom));
  endtask

  task send_load(logic [4:0] ci, logic [15:0] cv);
    send_item(REQ_LOAD, rgb_t'($urandom), ci, cv);
  endtask

  task send_other(req_t req);
    send_item(req, rgb_t'($urandom), 5'($urandom), 16'($urandom));
  endtask

  function logic [15:0] pick_coef();
    if ($urandom_range(0, 5) == 0) return 16'($urandom);
    return 16'(int'($urandom_range(0, 2400)) - 600);
  endfunction

  // wait until no result is outstanding and the pipeline is empty
  task settle();
    in_tvalid = 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (16) @(negedge clk);
  endtask

  task write_cfg(cfg_idx_t idx, logic [10:0] v);
    cfg_index = idx;
    cfg_data = v;
    cfg_we = 1'b1;
    @(posedge clk);
    sb.write_reg(idx, v);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task set_geometry(logic [10:0] w, logic [10:0] h, logic [10:0] fs, logic [10:0] gray);
    settle();
    write_cfg(CFG_WIDTH, w);
    write_cfg(CFG_HEIGHT, h);
    write_cfg(CFG_FSIZE, fs);
    write_cfg(CFG_GRAY, gray);
    settings_run++;
  endtask

  // one frame with noise; stops after cut pixels if cut is below the frame size
  task run_frame(int cut, bit hold_mid);
    int npix, r;
    npix = sb.eff_w() * sb.eff_h();
    for (int i = 0; i < npix && i < cut; i++) begin
      r = $urandom_range(0, 59);
      if (r < 4) send_load(5'($urandom_range(0, 31)), pick_coef());
      else if (r < 6) send_other(REQ_NONE);
      else if (r < 8) send_other(REQ_DRAIN);
      if (hold_mid && i == npix / 2) settle();
      send_pixel();
    end
    if (cut < npix) return;
    while (sb.got_frame) begin
      if ($urandom_range(0, 7) == 0) send_pixel();
      else send_other(REQ_DRAIN);
    end
    send_other(REQ_DRAIN);
  endtask

  initial begin
    int w, h;
    sb = new();
    items_sent = 0; settings_run = 0; idle_cycles = 0;
    calm_in = 0; calm_out = 0;
    rst_n = 1'b0;
    in_tvalid = 1'b0; in_tdata = '0; in_tuser = REQ_PIXEL;
    cfg_we = 1'b0; cfg_index = CFG_WIDTH; cfg_data = '0;
    repeat (6) @(negedge clk);
    rst_n = 1'b1;

    // directed: coefficient extremes, ignored load, idle codes, then a tiny frame
    send_load(5'd0, 16'h8000);
    send_load(5'd1, 16'h7fff);
    send_load(5'd2, 16'h0000);
    send_load(5'd3, 16'hffff);
    for (int i = 4; i < KERNEL_TAPS; i++) send_load(5'(i), 16'(i * 97));
    send_load(5'd31, 16'h1234);
    send_other(REQ_NONE);
    send_other(REQ_DRAIN);
    set_geometry(11'd2, 11'd2, 11'd1, 11'd0);
    send_load(5'd0, 16'h1000);
    send_item(REQ_PIXEL, '{8'hff, 8'h00, 8'hff}, 5'd0, 16'd0);
    send_item(REQ_PIXEL, '{8'h00, 8'hff, 8'h00}, 5'd31, 16'hffff);
    send_item(REQ_PIXEL, '{8'hff, 8'hff, 8'hff}, 5'd0, 16'd0);
    send_item(REQ_PIXEL, '{8'h00, 8'h00, 8'h00}, 5'd0, 16'd0);
    send_other(REQ_DRAIN);

    // widest row with clamped register values and a tall frame, both abandoned
    set_geometry(11'd2047, 11'd0, 11'd7, 11'd1);
    run_frame(150, 0);
    set_geometry(11'd1, 11'd2047, 11'd5, 11'd0);
    run_frame(40, 0);

    while (items_sent < 1000) begin
      calm_in = ($urandom_range(0, 3) == 0);
      calm_out = ($urandom_range(0, 3) == 0);
      w = $urandom_range(0, 9) == 0 ? $urandom_range(0, 40) : $urandom_range(1, 12);
      h = $urandom_range(0, 9) == 0 ? $urandom_range(0, 12) : $urandom_range(1, 6);
      set_geometry(11'(w), 11'(h), 11'($urandom_range(0, 7)), 11'($urandom_range(0, 1)));
      repeat ($urandom_range(0, 6)) send_load(5'($urandom_range(0, 24)), pick_coef());
      if ($urandom_range(0, 5) == 0) run_frame($urandom_range(0, 20), 0);
      else run_frame(1 << 20, $urandom_range(0, 9) == 0);
    end

    settle();
    calm_in = 0;
    $display("%0d items over %0d register settings, %0d results checked",
             items_sent, settings_run, sb.checked);
    if (sb.errors == 0) begin
      $display("rgb_window_convolution_unit: match");
    end else begin
      $display("rgb_window_convolution_unit: mismatch");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/rwc_pkg.sv
sv/rwc_line_mem.sv
sv/rgb_window_convolution_unit.sv
sim/tb_rgb_window_convolution_unit.sv
